@@ hw/rtl/mpd_pkg.sv @@
// Shared types, constants and the letter lookup for the Morse pulse decoder.
`timescale 1ns / 1ps

package mpd_pkg;

    localparam int MAX_SYMBOLS_DEF = 4;
    localparam int LETTER_COUNT    = 26;
    localparam int FIFO_DEPTH      = 4;

    typedef logic [6:0] t_char;

    typedef struct packed {
        logic  last;
        t_char code;
    } t_result;

    localparam logic [11:0] UNIT_RESET = 12'((512 / 4) / 16);
    localparam logic [7:0]  TOL_RESET  = 8'd5;

    localparam logic REG_UNIT = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    localparam t_char CH_A     = 7'h61;
    localparam t_char CH_QUEST = 7'h3F;
    localparam t_char CH_ONE   = 7'h31;
    localparam t_char CH_TWO   = 7'h32;
    localparam t_char CH_SPACE = 7'h20;

    localparam int UNITS_DOT        = 1;
    localparam int UNITS_DASH       = 3;
    localparam int UNITS_LETTER_GAP = 3 + 1;
    localparam int UNITS_WORD_GAP   = 7 + 3 + 1;

    // Symbol i of a letter sits in bit i; a one is a dot and a zero is a dash.
    localparam logic [2:0] LETTER_LEN [LETTER_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [3:0] LETTER_BITS [LETTER_COUNT] = '{
        4'b0001, 4'b1110, 4'b1010, 4'b0110, 4'b0001, 4'b1011, 4'b0100,
        4'b1111, 4'b0011, 4'b0001, 4'b0010, 4'b1101, 4'b0000, 4'b0010,
        4'b0000, 4'b1001, 4'b0100, 4'b0101, 4'b0111, 4'b0000, 4'b0011,
        4'b0111, 4'b0001, 4'b0110, 4'b0010, 4'b1100
    };

    function automatic t_char decode_letter(logic [3:0] cnt, logic [3:0] sym);
        t_char      code;
        logic [3:0] mask;
        code = CH_QUEST;
        for (int k = 0; k < LETTER_COUNT; k++) begin
            mask = 4'((5'd1 << LETTER_LEN[k]) - 5'd1);
            if ({1'b0, LETTER_LEN[k]} == cnt && (sym & mask) == LETTER_BITS[k]) begin
                code = CH_A + 7'(k);
            end
        end
        return code;
    endfunction

    // Open window test without wrap: centre - tol < d < centre + tol.
    function automatic logic in_window(logic [15:0] d, logic [15:0] centre,
                                       logic [7:0] tol);
        logic [16:0] d_plus;
        logic [16:0] c_plus;
        d_plus = {1'b0, d} + {9'd0, tol};
        c_plus = {1'b0, centre} + {9'd0, tol};
        return (d_plus > {1'b0, centre}) && ({1'b0, d} < c_plus);
    endfunction

endpackage

@@ hw/rtl/mpd_in_if.sv @@
// Edge event channel: timer value and interval kind.
`timescale 1ns / 1ps

interface mpd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] timestamp;
    logic        was_mark;

    modport source (output valid, output timestamp, output was_mark, input ready);
    modport sink   (input valid, input timestamp, input was_mark, output ready);
endinterface

@@ hw/rtl/mpd_out_if.sv @@
// Decoded character channel.
`timescale 1ns / 1ps

interface mpd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ hw/rtl/morse_pulse_decoder.sv @@
// Morse pulse decoder top level: edge timing windows, symbol buffer and output queue.
//
// Channel  Direction  Payload                        Transaction
// i_in     in         timestamp[15:0], was_mark      valid && ready
// o_out    out        char_code[6:0], last           valid && ready
// i_cfg_*  in         idx, data[11:0]                i_cfg_we high
//
// An accepted edge waits in the input register and is decoded from it once the queue has room.
// Its characters enter the output queue at the end of the decoding cycle and are offered from then on.
// Each edge gives zero to two characters, which enter a four-entry output queue.
// The input register drains whenever the queue has two free entries, so one edge a cycle is
// taken while that holds; the output sends one character a cycle while the consumer is ready.
// Reset clears the state, empties the queue and sets the unit and tolerance registers to their defaults.
`timescale 1ns / 1ps

module morse_pulse_decoder #(
    parameter int MAX_SYMBOLS = mpd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mpd_in_if.sink          i_in,
    mpd_out_if.source       o_out,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [11:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    localparam int IW = $clog2(MAX_SYMBOLS);

    logic [11:0]            r_unit;
    logic [7:0]             r_tol;
    logic                   r_in_valid;
    logic [15:0]            r_ts;
    logic                   r_mark;
    logic [15:0]            r_prev;
    logic [CW-1:0]          r_scnt;
    logic [MAX_SYMBOLS-1:0] r_store;
    logic                   r_ovf;

    mpd_pkg::t_result       r_fifo [mpd_pkg::FIFO_DEPTH];
    logic [1:0]             r_wptr;
    logic [1:0]             r_rptr;
    logic [2:0]             r_fcnt;

    logic                   fire;
    logic                   in_acc;
    logic                   out_acc;
    logic [15:0]            diff;
    logic [15:0]            c1, c3, c4, c11;
    logic                   w1, w3, w4, w11;
    mpd_pkg::t_char         letter;
    logic [1:0]             n_push;
    mpd_pkg::t_result       res0, res1;
    logic                   do_push_sym;
    logic                   sym_bit;
    logic                   do_clear;
    logic [2:0]             n_fcnt;

    assign fire    = r_in_valid && (r_fcnt <= 3'd2);
    assign i_in.ready = !r_in_valid || fire;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    assign o_out.valid     = (r_fcnt != 3'd0);
    assign o_out.char_code = r_fifo[r_rptr].code;
    assign o_out.last      = r_fifo[r_rptr].last;

    assign diff = r_ts - r_prev;
    assign c1   = {4'd0, r_unit};
    assign c3   = {3'd0, r_unit, 1'b0} + c1;
    assign c4   = {2'd0, r_unit, 2'b00};
    assign c11  = {1'b0, r_unit, 3'b000} + {3'd0, r_unit, 1'b0} + c1;

    assign w1  = mpd_pkg::in_window(diff, c1, r_tol);
    assign w3  = mpd_pkg::in_window(diff, c3, r_tol);
    assign w4  = mpd_pkg::in_window(diff, c4, r_tol);
    assign w11 = mpd_pkg::in_window(diff, c11, r_tol);

    assign letter = r_ovf ? mpd_pkg::CH_QUEST
                          : mpd_pkg::decode_letter(4'(r_scnt), r_store[3:0]);

    always_comb begin
        n_push      = 2'd0;
        res0        = '{last: 1'b1, code: letter};
        res1        = '{last: 1'b1, code: mpd_pkg::CH_SPACE};
        do_push_sym = 1'b0;
        sym_bit     = 1'b0;
        do_clear    = 1'b0;
        if (r_mark) begin
            if (w3) begin
                do_push_sym = 1'b1;
            end else if (w1) begin
                do_push_sym = 1'b1;
                sym_bit     = 1'b1;
            end else begin
                do_clear = 1'b1;
                n_push   = 2'd1;
                res0     = '{last: 1'b1, code: mpd_pkg::CH_ONE};
            end
        end else begin
            if (w11) begin
                do_clear = 1'b1;
                n_push   = 2'd2;
                res0     = '{last: 1'b0, code: letter};
            end else if (w4) begin
                do_clear = 1'b1;
                n_push   = 2'd1;
            end else if (!w1) begin
                do_clear = 1'b1;
                n_push   = 2'd1;
                res0     = '{last: 1'b1, code: mpd_pkg::CH_TWO};
            end
        end
    end

    always_comb begin
        n_fcnt = r_fcnt;
        if (fire) begin
            n_fcnt = n_fcnt + {1'b0, n_push};
        end
        if (out_acc) begin
            n_fcnt = n_fcnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit     <= mpd_pkg::UNIT_RESET;
            r_tol      <= mpd_pkg::TOL_RESET;
            r_in_valid <= 1'b0;
            r_prev     <= 16'd0;
            r_scnt     <= '0;
            r_ovf      <= 1'b0;
            r_wptr     <= 2'd0;
            r_rptr     <= 2'd0;
            r_fcnt     <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mpd_pkg::REG_UNIT) begin
                    r_unit <= i_cfg_data;
                end else begin
                    r_tol <= i_cfg_data[7:0];
                end
            end
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_prev <= r_ts;
                r_wptr <= r_wptr + n_push;
                if (do_clear) begin
                    r_scnt <= '0;
                    r_ovf  <= 1'b0;
                end else if (do_push_sym) begin
                    if (r_scnt < CW'(MAX_SYMBOLS)) begin
                        r_scnt <= r_scnt + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (out_acc) begin
                r_rptr <= r_rptr + 2'd1;
            end
            r_fcnt <= n_fcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ts   <= i_in.timestamp;
            r_mark <= i_in.was_mark;
        end
        if (fire && do_push_sym && !do_clear && r_scnt < CW'(MAX_SYMBOLS)) begin
            r_store[r_scnt[IW-1:0]] <= sym_bit;
        end
        if (fire && n_push != 2'd0) begin
            r_fifo[r_wptr] <= res0;
        end
        if (fire && n_push == 2'd2) begin
            r_fifo[r_wptr + 2'd1] <= res1;
        end
    end

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= 3'(mpd_pkg::FIFO_DEPTH))
        else $error("Output queue count exceeds its depth.");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_push == 2'd2 |=> r_fcnt >= 3'd2)
        else $error("A word gap did not leave both characters queued.");

    a_sym_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scnt <= CW'(MAX_SYMBOLS))
        else $error("Symbol count exceeds the buffer size.");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_scnt == CW'(MAX_SYMBOLS))
        else $error("Overflow flag set while the symbol buffer is not full.");

endmodule
